[hw/rtl/integer_to_ascii_formatter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Shared property wrappers for the checker of the formatter unit.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define IFMT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IFMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ifmt_pkg.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Payload types, microcode format and the control program.
// ----------------------------------------------------------------------------
package ifmt_pkg;

   localparam int WORD_BITS = 32;
   // decimal digits needed for the magnitude: floor(W * log10(2)) + 1
   localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
   localparam int DIGIT_BITS = DEC_DIGITS * 4;
   localparam int BIT_CNT_BITS = $clog2(WORD_BITS + 1);
   localparam int DIG_CNT_BITS = $clog2(DEC_DIGITS + 1);
   localparam int STEP_BITS = 4;

   localparam logic [6:0] CHAR_MINUS = 7'd45;
   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_UPPER_A = 7'd65;
   localparam logic [6:0] CHAR_X     = 7'd120;

   typedef enum logic {
      MODE_DEC = 1'b0,
      MODE_HEX = 1'b1
   } mode_type;

   typedef struct packed {
      logic                 req_type;
      logic [WORD_BITS-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_EMIT,
      OP_DABBLE,
      OP_DIGIT
   } uop_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_HEX,
      COND_POS,
      COND_BIT_MORE,
      COND_DIGIT_MORE
   } cond_type;

   typedef struct packed {
      uop_type              op;
      logic [6:0]           emit_char;
      cond_type             cond;
      logic [STEP_BITS-1:0] target;
   } ctrl_word_type;

   // sequencer -> datapath
   typedef struct packed {
      uop_type op;
      logic    fire;
   } dp_ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic       hex;
      logic       neg;
      logic       bit_more;
      logic       digit_more;
      logic       skip;
      logic [6:0] digit_char;
   } dp_status_type;

   localparam logic [STEP_BITS-1:0] STEP_IDLE   = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_DABBLE = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_DIGITS = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_PREFIX = 4'd7;

   // control program; a step that does not jump falls through to the next one
   function automatic ctrl_word_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ctrl_word_type w;
      w = '{op: OP_NOP, emit_char: CHAR_ZERO, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (step)
         4'd0: w = '{op: OP_LOAD,   emit_char: CHAR_ZERO,  cond: COND_NONE,
                     target: STEP_IDLE};
         4'd1: w = '{op: OP_NOP,    emit_char: CHAR_ZERO,  cond: COND_HEX,
                     target: STEP_PREFIX};
         4'd2: w = '{op: OP_NOP,    emit_char: CHAR_ZERO,  cond: COND_POS,
                     target: STEP_DABBLE};
         4'd3: w = '{op: OP_EMIT,   emit_char: CHAR_MINUS, cond: COND_NONE,
                     target: STEP_IDLE};
         4'd4: w = '{op: OP_DABBLE, emit_char: CHAR_ZERO,  cond: COND_BIT_MORE,
                     target: STEP_DABBLE};
         4'd5: w = '{op: OP_DIGIT,  emit_char: CHAR_ZERO,  cond: COND_DIGIT_MORE,
                     target: STEP_DIGITS};
         4'd6: w = '{op: OP_NOP,    emit_char: CHAR_ZERO,  cond: COND_ALWAYS,
                     target: STEP_IDLE};
         4'd7: w = '{op: OP_EMIT,   emit_char: CHAR_ZERO,  cond: COND_NONE,
                     target: STEP_IDLE};
         4'd8: w = '{op: OP_EMIT,   emit_char: CHAR_X,     cond: COND_ALWAYS,
                     target: STEP_DIGITS};
         default: w = '{op: OP_NOP, emit_char: CHAR_ZERO,  cond: COND_ALWAYS,
                        target: STEP_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [6:0] nibble_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib >= 4'd10) begin
         c = CHAR_UPPER_A + {3'b000, nib} - 7'd10;
      end else begin
         c = CHAR_ZERO + {3'b000, nib};
      end
      return c;
   endfunction

endpackage

[hw/rtl/ifmt_datapath.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter datapath
// Magnitude and BCD/hex digit registers, shift-add-3 step and digit output.
// ----------------------------------------------------------------------------
module ifmt_datapath (
   input  logic                     clock,
   input  ifmt_pkg::dp_ctrl_type    ctrl,
   input  ifmt_pkg::req_payload_type req_payload,
   output ifmt_pkg::dp_status_type  status
);

   localparam int W  = ifmt_pkg::WORD_BITS;
   localparam int ND = ifmt_pkg::DEC_DIGITS;
   localparam int DW = ifmt_pkg::DIGIT_BITS;
   localparam int BCW = ifmt_pkg::BIT_CNT_BITS;
   localparam int DCW = ifmt_pkg::DIG_CNT_BITS;

   logic [W-1:0]   mag_ff, mag_in;
   logic [DW-1:0]  digits_ff, digits_in;
   logic [DW-1:0]  adjusted;
   logic [BCW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0] dig_cnt_ff, dig_cnt_in;
   logic           hex_ff, hex_in;
   logic           neg_ff, neg_in;
   logic           started_ff, started_in;
   logic [3:0]     top_digit;
   logic           skip;

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         if (digits_ff[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = digits_ff[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = digits_ff[i*4 +: 4];
         end
      end
   end

   assign top_digit = digits_ff[DW-1 -: 4];
   assign skip = !started_ff && (top_digit == 4'd0) && (dig_cnt_ff != DCW'(1));

   always_comb begin
      mag_in     = mag_ff;
      digits_in  = digits_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      hex_in     = hex_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      if (ctrl.fire) begin
         unique case (ctrl.op)
            ifmt_pkg::OP_LOAD: begin
               hex_in     = (req_payload.req_type == ifmt_pkg::MODE_HEX);
               neg_in     = (req_payload.req_type == ifmt_pkg::MODE_DEC)
                            && req_payload.value[W-1];
               mag_in     = neg_in ? (~req_payload.value + W'(1)) : req_payload.value;
               digits_in  = hex_in ? DW'(req_payload.value) : '0;
               bit_cnt_in = BCW'(W);
               dig_cnt_in = DCW'(ND);
               started_in = 1'b0;
            end
            ifmt_pkg::OP_DABBLE: begin
               digits_in  = {adjusted[DW-2:0], mag_ff[W-1]};
               mag_in     = {mag_ff[W-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - BCW'(1);
            end
            ifmt_pkg::OP_DIGIT: begin
               digits_in  = {digits_ff[DW-5:0], 4'b0000};
               dig_cnt_in = dig_cnt_ff - DCW'(1);
               started_in = started_ff | !skip;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      digits_ff  <= digits_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      hex_ff     <= hex_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
   end

   assign status.hex        = hex_ff;
   assign status.neg        = neg_ff;
   assign status.bit_more   = (bit_cnt_ff != BCW'(1));
   assign status.digit_more = (dig_cnt_ff != DCW'(1));
   assign status.skip       = skip;
   assign status.digit_char = ifmt_pkg::nibble_char(top_digit);

endmodule

[hw/rtl/integer_to_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter unit
// Microcoded converter from a 32-bit word to decimal or 0x-hex ASCII text.
// ----------------------------------------------------------------------------
// - req: mode (req_type: 0 signed decimal, 1 hex) and a 32-bit value.
//   req_stall is low only in the idle step outside reset: one value at a time.
// - rsp: one transfer per character, most significant first, last set on the
//   final one (1 to 11 characters per value).
// - Steps depend only on mode and sign: a decimal value takes a shift-add-3
//   pass over all 32 bits, a negative one after a minus step; both modes
//   then take 10 digit steps, leading zeros with no output. The first
//   character is the 0 of the prefix in hex, the minus sign for a negative
//   decimal, else the first digit after the pass.
// - One output register holds the pending character; while rsp_stall holds it
//   there, the sequencer waits at its next character step; a skipped leading
//   zero does not wait.
// - Reset: synchronous, clears the step counter and the output valid; the
//   unit takes a request in the first cycle after reset drops.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ifmt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ifmt_pkg::rsp_payload_type rsp_payload
);

   localparam int SB = ifmt_pkg::STEP_BITS;

   logic [SB-1:0]             step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ifmt_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   ifmt_pkg::ctrl_word_type   uword;
   ifmt_pkg::dp_ctrl_type     dp_ctrl;
   ifmt_pkg::dp_status_type   dp_status;
   logic                      slot_free;
   logic                      fire;
   logic                      emit;
   logic                      take_jump;

   assign uword     = ifmt_pkg::ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (uword.op)
         ifmt_pkg::OP_LOAD:  fire = req_valid;
         ifmt_pkg::OP_EMIT:  fire = slot_free;
         ifmt_pkg::OP_DIGIT: fire = dp_status.skip || slot_free;
         default:            fire = 1'b1;
      endcase
   end

   assign emit = fire && ((uword.op == ifmt_pkg::OP_EMIT)
                 || ((uword.op == ifmt_pkg::OP_DIGIT) && !dp_status.skip));

   always_comb begin
      unique case (uword.cond)
         ifmt_pkg::COND_NONE:       take_jump = 1'b0;
         ifmt_pkg::COND_ALWAYS:     take_jump = 1'b1;
         ifmt_pkg::COND_HEX:        take_jump = dp_status.hex;
         ifmt_pkg::COND_POS:        take_jump = !dp_status.neg;
         ifmt_pkg::COND_BIT_MORE:   take_jump = dp_status.bit_more;
         ifmt_pkg::COND_DIGIT_MORE: take_jump = dp_status.digit_more;
         default:                   take_jump = 1'b0;
      endcase
   end

   always_comb begin
      priority if (!fire) begin
         step_in = step_ff;
      end else if (take_jump) begin
         step_in = uword.target;
      end else begin
         step_in = step_ff + SB'(1);
      end
   end

   always_comb begin
      rsp_valid_in   = emit || (rsp_valid_ff && rsp_stall);
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         if (uword.op == ifmt_pkg::OP_DIGIT) begin
            rsp_payload_in.character = dp_status.digit_char;
            rsp_payload_in.last      = !dp_status.digit_more;
         end else begin
            rsp_payload_in.character = uword.emit_char;
            rsp_payload_in.last      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ifmt_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign dp_ctrl.op   = uword.op;
   assign dp_ctrl.fire = fire;

   ifmt_datapath u_datapath (
      .clock       (clock),
      .ctrl        (dp_ctrl),
      .req_payload (req_payload),
      .status      (dp_status)
   );

   // no request transfer while reset holds the sequencer
   assign req_stall   = reset || (uword.op != ifmt_pkg::OP_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[hw/rtl/ifmt_checker.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter checker
// Port-level properties of the formatter unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_unit_defines.svh"

module ifmt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input ifmt_pkg::rsp_payload_type rsp_payload
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [6:0] ch;
   logic       is_digit;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign ch       = rsp_payload.character;
   assign is_digit = ((ch >= 7'd48) && (ch <= 7'd57)) || ((ch >= 7'd65) && (ch <= 7'd70));

   // a held character must not move
   `IFMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload), "rsp payload changed while stalled")

   // once a request is taken the unit is busy converting it
   `IFMT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall,
      "request taken while previous one still converting")

   // no new request while characters of the current value are still due
   `IFMT_ASSERT_IMPLY(a_no_req_mid_text, clock, reset, rsp_xfer && !rsp_payload.last,
      req_stall, "request channel open in the middle of a value")

   // text always ends on a digit
   `IFMT_ASSERT_IMPLY(a_last_is_digit, clock, reset, rsp_valid && rsp_payload.last,
      is_digit, "final character is not a digit")

endmodule

bind integer_to_ascii_formatter_unit ifmt_checker u_ifmt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[bench/tb_integer_to_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// Integer to ASCII formatter unit testbench
// Sends 32-bit words in signed decimal and hex mode and checks every ASCII
// character and last flag that comes back against the table text or a behavioral formatter.
// A directed table covers zero, the extremes and digit roll-overs. Random
// words and random idling on both channels follow, with one long receiver
// hold-off and one full drain in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_unit;

   localparam int RANDOM_WORDS = 228;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   ifmt_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   ifmt_pkg::rsp_payload_type rsp_payload;

   ifmt_pkg::rsp_payload_type pending_chars[$];
   ifmt_pkg::req_payload_type table_words[$];
   string                     table_text[$];
   int                        error_count = 0;
   int                        cycle_count = 0;
   bit                        send_no_gap = 1'b0;

   integer_to_ascii_formatter_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // expected text of one word, queued one character per transfer
   function automatic void queue_word_text(input ifmt_pkg::req_payload_type item);
      logic [ifmt_pkg::WORD_BITS-1:0] mag;
      logic [6:0]                     text[$];
      logic [6:0]                     digits[$];
      logic [3:0]                     nib;
      ifmt_pkg::rsp_payload_type      ch;
      mag = item.value;
      if (item.req_type == ifmt_pkg::MODE_HEX) begin
         text.push_back(ifmt_pkg::CHAR_ZERO);
         text.push_back(ifmt_pkg::CHAR_X);
         do begin
            nib = mag[3:0];
            if (nib >= 4'd10) digits.push_front(ifmt_pkg::CHAR_UPPER_A + 7'(nib - 4'd10));
            else digits.push_front(ifmt_pkg::CHAR_ZERO + 7'(nib));
            mag = mag >> 4;
         end while (mag != '0);
      end else begin
         if (mag[ifmt_pkg::WORD_BITS-1]) begin
            text.push_back(ifmt_pkg::CHAR_MINUS);
            mag = ~mag + 1'b1;   // unsigned magnitude, safe for the most negative word
         end
         do begin
            digits.push_front(ifmt_pkg::CHAR_ZERO + 7'(mag % 10));
            mag = mag / 10;
         end while (mag != '0);
      end
      text = {text, digits};
      foreach (text[i]) begin
         ch.character = text[i];
         ch.last      = (i == text.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic void queue_typed_text(input string s);
      ifmt_pkg::rsp_payload_type ch;
      for (int i = 0; i < s.len(); i++) begin
         ch.character = 7'(s[i]);
         ch.last      = (i == s.len() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   task automatic add_row(input ifmt_pkg::mode_type mode,
                          input logic [ifmt_pkg::WORD_BITS-1:0] value,
                          input string text);
      ifmt_pkg::req_payload_type item;
      item.req_type = mode;
      item.value    = value;
      table_words.push_back(item);
      table_text.push_back(text);
   endtask

   // one request transfer; an empty text means the formatter supplies the expectation
   task automatic send_word(input ifmt_pkg::req_payload_type item, input string text);
      int gap;
      gap = send_no_gap ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (text.len() > 0) queue_typed_text(text);
      else queue_word_text(item);
   endtask

   function automatic logic [ifmt_pkg::WORD_BITS-1:0] random_word();
      logic [ifmt_pkg::WORD_BITS-1:0] w;
      logic [ifmt_pkg::WORD_BITS-1:0] p;
      int                             k;
      case ($urandom_range(0, 6))
         0, 1: w = $urandom;
         2: w = $urandom_range(0, 99);
         3: w = -$urandom_range(1, 99);
         4: w = $urandom >> $urandom_range(0, 31);
         5: begin
            // near a power of ten, either sign
            k = $urandom_range(0, 9);
            p = 1;
            repeat (k) p = p * 10;
            w = p + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) w = -w;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: w = 32'h8000_0000;
               1: w = 32'h7FFF_FFFF;
               2: w = 32'hFFFF_FFFF;
               3: w = '0;
               default: w = (32'h1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
            endcase
         end
      endcase
      return w;
   endfunction

   // result checker
   always @(posedge clock) begin
      ifmt_pkg::rsp_payload_type exp_ch;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected character transfer: char=%0d last=%0b",
                        rsp_payload.character, rsp_payload.last);
         end else begin
            exp_ch = pending_chars.pop_front();
            if (rsp_payload.character !== exp_ch.character ||
                rsp_payload.last !== exp_ch.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: char exp=%0d got=%0d, last exp=%0b got=%0b",
                           exp_ch.character, rsp_payload.character,
                           exp_ch.last, rsp_payload.last);
            end
         end
      end
   end

   // receiver back-pressure, with one long hold-off so the unit backs up
   initial begin
      int  hold;
      int  transfers;
      bit  no_gap;
      transfers = 0;
      no_gap    = 1'b0;
      forever begin
         if (transfers % 24 == 0) no_gap = ($urandom_range(0, 3) == 0);
         if (transfers == HOLD_AT) hold = HOLD_CYCLES;
         else hold = no_gap ? 0 : $urandom_range(0, 10);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(!reset && rsp_valid && !rsp_stall));
         transfers++;
      end
   end

   initial begin
      ifmt_pkg::req_payload_type item;
      add_row(ifmt_pkg::MODE_DEC, 32'h0000_0000, "0");
      add_row(ifmt_pkg::MODE_HEX, 32'h0000_0000, "0x0");
      add_row(ifmt_pkg::MODE_DEC, 32'h8000_0000, "-2147483648");
      add_row(ifmt_pkg::MODE_DEC, 32'h7FFF_FFFF, "2147483647");
      add_row(ifmt_pkg::MODE_DEC, 32'hFFFF_FFFF, "-1");
      add_row(ifmt_pkg::MODE_HEX, 32'hFFFF_FFFF, "0xFFFFFFFF");
      add_row(ifmt_pkg::MODE_HEX, 32'h8000_0000, "0x80000000");
      add_row(ifmt_pkg::MODE_HEX, 32'h7FFF_FFFF, "0x7FFFFFFF");
      add_row(ifmt_pkg::MODE_DEC, 32'd1, "1");
      add_row(ifmt_pkg::MODE_DEC, 32'd9, "9");
      add_row(ifmt_pkg::MODE_DEC, 32'd10, "10");
      add_row(ifmt_pkg::MODE_DEC, 32'hFFFF_FFF6, "-10");
      add_row(ifmt_pkg::MODE_DEC, 32'd1000000000, "1000000000");
      add_row(ifmt_pkg::MODE_DEC, 32'd999999999, "");
      add_row(ifmt_pkg::MODE_HEX, 32'h0000_0009, "0x9");
      add_row(ifmt_pkg::MODE_HEX, 32'h0000_000A, "0xA");
      add_row(ifmt_pkg::MODE_HEX, 32'h0000_0010, "0x10");
      add_row(ifmt_pkg::MODE_HEX, 32'h0123_ABCD, "");
      add_row(ifmt_pkg::MODE_HEX, 32'h00F0_0000, "");
      add_row(ifmt_pkg::MODE_DEC, 32'h1234_5678, "");
      add_row(ifmt_pkg::MODE_DEC, 32'hDEAD_BEEF, "");
      add_row(ifmt_pkg::MODE_DEC, 32'h8000_0001, "");

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_words[i]) send_word(table_words[i], table_text[i]);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 16 == 0) send_no_gap = ($urandom_range(0, 3) == 0);
         // sender pause: drop valid, then let every expected character come out
         if (n == RANDOM_WORDS / 2) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_chars.size() != 0) @(posedge clock);
         end
         item.req_type = 1'($urandom_range(0, 1));
         item.value    = random_word();
         send_word(item, "");
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
